// ----- hw/rtl/pso_pkg.sv -----
// Shared widths, register indexes and state codes for the pulse speedometer.
package pso_pkg;

    // Field and state widths
    localparam int TIME_BITS   = 48;
    localparam int SPEED_BITS  = 24;
    localparam int FACTOR_BITS = 40;
    localparam int DPE_BITS    = 24;
    localparam int STOP_BITS   = 32;
    localparam int COUNT_BITS  = 32;
    localparam int DIST_BITS   = 56;

    // Serial unit step counts
    localparam int DIV_STEPS    = FACTOR_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
    localparam int MUL_STEPS    = COUNT_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_STEPS + 1);

    // Configuration port
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 64;
    localparam int REG_IDX_BITS = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_SPEED_FACTOR = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_DIST_PER_EDGE = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_STOP_INTERVAL = 2'd2;
    localparam logic [STOP_BITS-1:0] STOP_RESET = 32'd1000000;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ----- hw/rtl/pulse_speedometer_odometer.sv -----
// Top level: wheel pulse speedometer and odometer with APB register port.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one pin sample per beat:
//   i_pin_level and the microsecond i_timestamp_us. Every sample yields one
//   result beat on the output channel (o_out_valid / i_out_ready): edge
//   count, held speed (km/h Q8), distance (m Q16) and an edge flag.
//   Registers (APB, 64-bit data, byte address 8*index): speed_factor,
//   distance_per_edge, stop_interval_us. Write them only while idle.
// Sequence:
//   After the accepting edge the serial multiplier runs its 32 steps; the
//   sequencer leaves S_CALC once it sees both units idle, and the result is
//   loaded into the output register from S_DONE. A falling edge with an
//   earlier edge time also runs the 40-step serial divider, which then sets
//   when the result is loaded. A new sample is accepted only in S_IDLE,
//   after the previous result has been loaded into the output register.
// Reset and stall:
//   Synchronous active-low reset clears the state and loads the register
//   defaults (stop interval 1000000 us). A result waiting in the output
//   register does not block acceptance of the next sample; the block only
//   stalls before loading a new result while the old one is still unread.
module pulse_speedometer_odometer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_pin_level,
    input  logic [pso_pkg::TIME_BITS-1:0]     i_timestamp_us,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pso_pkg::COUNT_BITS-1:0]    o_edge_count,
    output logic [pso_pkg::SPEED_BITS-1:0]    o_speed_kmh_q8,
    output logic [pso_pkg::DIST_BITS-1:0]     o_distance_q16,
    output logic                              o_edge_seen,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pso_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [pso_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [pso_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);

    pso_pkg::t_state                      r_state;
    pso_pkg::t_state                      n_state;

    // configuration registers
    logic [pso_pkg::FACTOR_BITS-1:0]      r_speed_factor;
    logic [pso_pkg::DPE_BITS-1:0]         r_dist_per_edge;
    logic [pso_pkg::STOP_BITS-1:0]        r_stop_interval;

    // block state
    logic                                 r_prev_level;
    logic [pso_pkg::TIME_BITS-1:0]        r_last_edge;
    logic [pso_pkg::COUNT_BITS-1:0]       r_total;
    logic [pso_pkg::SPEED_BITS-1:0]       r_held_speed;

    // per-item working registers
    logic [pso_pkg::TIME_BITS-1:0]        r_now;
    logic                                 r_edge;
    logic                                 r_use_div;
    logic                                 r_stop;

    // output register
    logic                                 r_out_valid;
    logic [pso_pkg::COUNT_BITS-1:0]       r_out_count;
    logic [pso_pkg::SPEED_BITS-1:0]       r_out_speed;
    logic [pso_pkg::DIST_BITS-1:0]        r_out_dist;
    logic                                 r_out_edge;

    logic                                 w_accept;
    logic                                 w_edge;
    logic                                 w_do_div;
    logic [pso_pkg::COUNT_BITS-1:0]       n_total;
    logic [pso_pkg::TIME_BITS-1:0]        w_period;
    logic [pso_pkg::TIME_BITS-1:0]        w_elapsed;
    logic                                 w_out_free;
    logic                                 w_load_out;
    logic                                 w_cfg_wr;
    logic [pso_pkg::REG_IDX_BITS-1:0]     w_reg_idx;
    logic                                 w_div_busy;
    logic                                 w_mul_busy;
    logic [pso_pkg::SPEED_BITS-1:0]       w_quotient;
    logic [pso_pkg::DIST_BITS-1:0]        w_product;
    logic [pso_pkg::SPEED_BITS-1:0]       w_new_speed;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[pso_pkg::PADDR_BITS-1:3];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_factor  <= '0;
            r_dist_per_edge <= '0;
            r_stop_interval <= pso_pkg::STOP_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                pso_pkg::REG_SPEED_FACTOR: begin
                    r_speed_factor <= pwdata[pso_pkg::FACTOR_BITS-1:0];
                end
                pso_pkg::REG_DIST_PER_EDGE: begin
                    r_dist_per_edge <= pwdata[pso_pkg::DPE_BITS-1:0];
                end
                pso_pkg::REG_STOP_INTERVAL: begin
                    r_stop_interval <= pwdata[pso_pkg::STOP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            pso_pkg::REG_SPEED_FACTOR: begin
                prdata = pso_pkg::PDATA_BITS'(r_speed_factor);
            end
            pso_pkg::REG_DIST_PER_EDGE: begin
                prdata = pso_pkg::PDATA_BITS'(r_dist_per_edge);
            end
            pso_pkg::REG_STOP_INTERVAL: begin
                prdata = pso_pkg::PDATA_BITS'(r_stop_interval);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ---------------- accept: edge detect and unit launch ----------------
    assign o_in_ready = (r_state == pso_pkg::S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_edge     = r_prev_level & ~i_pin_level;
    assign w_period   = i_timestamp_us - r_last_edge;
    assign w_do_div   = w_accept & w_edge & (r_last_edge != '0);
    assign n_total    = (w_edge && (r_total != '1)) ? r_total + 1'b1 : r_total;

    pso_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_do_div),
        .i_dividend (r_speed_factor),
        .i_divisor  (w_period),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    pso_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_count    (n_total),
        .i_mult     (r_dist_per_edge),
        .o_busy     (w_mul_busy),
        .o_product  (w_product)
    );

    // ---------------- sequencer ----------------
    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_load_out = (r_state == pso_pkg::S_DONE) & w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pso_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = pso_pkg::S_CALC;
                end
            end
            pso_pkg::S_CALC: begin
                if (!w_div_busy && !w_mul_busy) begin
                    n_state = pso_pkg::S_DONE;
                end
            end
            pso_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = pso_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pso_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pso_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- per-sample state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_last_edge  <= '0;
            r_total      <= '0;
        end else if (w_accept) begin
            r_prev_level <= i_pin_level;
            r_total      <= n_total;
            if (w_edge) begin
                r_last_edge <= i_timestamp_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now     <= i_timestamp_us;
            r_edge    <= w_edge;
            r_use_div <= w_do_div;
        end
    end

    // stop test against the edge time after this sample's update, no wrap
    assign w_elapsed = r_now - r_last_edge;

    always_ff @(posedge i_clk) begin
        if (r_state == pso_pkg::S_CALC) begin
            r_stop <= (r_now > r_last_edge) &&
                      (w_elapsed > pso_pkg::TIME_BITS'(r_stop_interval));
        end
    end

    // held speed: new quotient on a timed edge, then forced stop
    always_comb begin
        w_new_speed = r_held_speed;
        if (r_use_div) begin
            w_new_speed = w_quotient;
        end
        if (r_stop) begin
            w_new_speed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_speed <= '0;
        end else if (w_load_out) begin
            r_held_speed <= w_new_speed;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_count <= r_total;
            r_out_speed <= w_new_speed;
            r_out_dist  <= w_product;
            r_out_edge  <= r_edge;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_edge_count   = r_out_count;
    assign o_speed_kmh_q8 = r_out_speed;
    assign o_distance_q16 = r_out_dist;
    assign o_edge_seen    = r_out_edge;

endmodule

// ----- hw/rtl/pso_div.sv -----
// Bit-serial restoring divider: speed factor over edge period, saturating quotient.
module pso_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pso_pkg::FACTOR_BITS-1:0]  i_dividend,
    input  logic [pso_pkg::TIME_BITS-1:0]    i_divisor,
    output logic                             o_busy,
    output logic [pso_pkg::SPEED_BITS-1:0]   o_quotient
);

    logic                                r_busy;
    logic [pso_pkg::DIV_CNT_BITS-1:0]    r_cnt;
    logic [pso_pkg::TIME_BITS-1:0]       r_rem;
    logic [pso_pkg::FACTOR_BITS-1:0]     r_dvd;
    logic [pso_pkg::TIME_BITS-1:0]       r_dsr;
    logic [pso_pkg::SPEED_BITS-1:0]      r_quo;
    logic                                r_ovf;
    logic                                r_zero;

    logic [pso_pkg::TIME_BITS:0]         w_shift;
    logic [pso_pkg::TIME_BITS+1:0]       w_diff;
    logic                                w_ge;

    // One quotient bit per cycle: shift in next dividend bit, trial subtract
    assign w_shift = {r_rem, r_dvd[pso_pkg::FACTOR_BITS-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dsr};
    assign w_ge    = ~w_diff[pso_pkg::TIME_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pso_pkg::DIV_CNT_BITS'(pso_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == pso_pkg::DIV_CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
            r_quo  <= '0;
            r_ovf  <= 1'b0;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[pso_pkg::TIME_BITS-1:0]
                          : w_shift[pso_pkg::TIME_BITS-1:0];
            r_dvd <= {r_dvd[pso_pkg::FACTOR_BITS-2:0], 1'b0};
            r_quo <= {r_quo[pso_pkg::SPEED_BITS-2:0], w_ge};
            // a one pushed past the top bit means the quotient is out of range
            r_ovf <= r_ovf | r_quo[pso_pkg::SPEED_BITS-1];
        end
    end

    // Zero period gives zero speed; overflow clamps to full scale
    always_comb begin
        if (r_zero) begin
            o_quotient = '0;
        end else if (r_ovf) begin
            o_quotient = '1;
        end else begin
            o_quotient = r_quo;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- hw/rtl/pso_mul.sv -----
// Bit-serial shift-add multiplier: edge count times distance per edge.
module pso_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pso_pkg::COUNT_BITS-1:0]   i_count,
    input  logic [pso_pkg::DPE_BITS-1:0]     i_mult,
    output logic                             o_busy,
    output logic [pso_pkg::DIST_BITS-1:0]    o_product
);

    logic                                r_busy;
    logic [pso_pkg::MUL_CNT_BITS-1:0]    r_cnt;
    logic [pso_pkg::DPE_BITS-1:0]        r_md;
    logic [pso_pkg::DPE_BITS-1:0]        r_hi;
    logic [pso_pkg::COUNT_BITS-1:0]      r_lo;
    logic [pso_pkg::DPE_BITS:0]          w_sum;

    // Add multiplicand when the current count bit is set, then shift right
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_md} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pso_pkg::MUL_CNT_BITS'(pso_pkg::MUL_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == pso_pkg::MUL_CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Product accumulates in hi, low bits shift into lo
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_md <= i_mult;
            r_hi <= '0;
            r_lo <= i_count;
        end else if (r_busy) begin
            r_hi <= w_sum[pso_pkg::DPE_BITS:1];
            r_lo <= {w_sum[0], r_lo[pso_pkg::COUNT_BITS-1:1]};
        end
    end

    // 32 x 24 bits always fits in 56 bits, so no clamp is needed
    assign o_product = {r_hi, r_lo};
    assign o_busy    = r_busy;

endmodule
